// File: rtl/bpr_pkg.sv
// ----------------------------------------------------------------------------
// bpr_pkg
// Types and constants shared by the button press reporter and its checker.
// ----------------------------------------------------------------------------
package bpr_pkg;

   localparam int NUM_BUTTONS = 3;
   localparam int MASK_W      = 3;
   localparam int TIME_W      = 32;
   localparam int CFG_W       = 16;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CFG_W-1:0] LOCKOUT_RESET = 16'd250;
   localparam logic [CFG_W-1:0] PERIOD_RESET  = 16'd100;
   localparam logic [CFG_W-1:0] HOLD_RESET    = 16'd1000;

   typedef enum logic [1:0] {
      KIND_PIN     = 2'd0,
      KIND_TICK    = 2'd1,
      KIND_CONFIRM = 2'd2,
      KIND_LED     = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOCKOUT = 2'd0,
      CSR_PERIOD  = 2'd1,
      CSR_HOLD    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        button_index;
      logic              level;
      logic [TIME_W-1:0] now_ms;
      logic [MASK_W-1:0] state_mask;
      logic [1:0]        state_count;
   } req_type;

   typedef struct packed {
      logic              report_valid;
      logic [MASK_W-1:0] report_mask;
      logic [MASK_W-1:0] led_mask;
   } rsp_type;

endpackage

// File: rtl/button_press_report_with_ack.sv
// ----------------------------------------------------------------------------
// button_press_report_with_ack
// Latches button presses, reports pressed states on service ticks until
// they are confirmed, and holds LED drive bits.
// ----------------------------------------------------------------------------
// The response is registered and is valid in the cycle after a request transfer.
// Throughput: one request per cycle; a request is taken while the response
// register is empty or is being drained in the same cycle.
// Reset (synchronous): all registers but the response payload back to their
// defaults, all buttons released and unpressed, no response pending.
// ----------------------------------------------------------------------------
module button_press_report_with_ack (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bpr_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bpr_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bpr_pkg::CFG_W-1:0]           csr_data
);

   localparam int N = bpr_pkg::NUM_BUTTONS;

   logic [bpr_pkg::CFG_W-1:0]  lockout_ff, lockout_in;
   logic [bpr_pkg::CFG_W-1:0]  period_ff, period_in;
   logic [bpr_pkg::CFG_W-1:0]  hold_ff, hold_in;

   logic [N-1:0]               pressed_ff, pressed_in;
   logic [N-1:0]               released_ff, released_in;
   logic [N-1:0]               confirmed_ff, confirmed_in;
   logic [N-1:0]               led_ff, led_in;
   logic [bpr_pkg::TIME_W-1:0] last_press_ff [N];
   logic [bpr_pkg::TIME_W-1:0] last_press_in [N];
   logic [bpr_pkg::TIME_W-1:0] last_report_ff, last_report_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   bpr_pkg::rsp_type           rsp_ff, rsp_in;

   logic                       req_fire;
   logic [bpr_pkg::TIME_W-1:0] report_age;
   logic                       tick_due;
   logic                       send;
   logic [N-1:0]               hit;
   logic [N-1:0]               lock_clear;
   logic [N-1:0]               hold_expired;
   logic [N-1:0]               write_en;
   logic [bpr_pkg::MASK_W-1:0] pressed_mask;
   logic [bpr_pkg::MASK_W-1:0] led_mask_next;

   assign csr_ready   = 1'b1;
   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      lockout_in = lockout_ff;
      period_in  = period_ff;
      hold_in    = hold_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bpr_pkg::CSR_LOCKOUT: lockout_in = csr_data;
            bpr_pkg::CSR_PERIOD:  period_in  = csr_data;
            bpr_pkg::CSR_HOLD:    hold_in    = csr_data;
            default:              ;
         endcase
      end
   end

   assign report_age = req_payload.now_ms - last_report_ff;
   assign tick_due   = report_age > {16'd0, period_ff};
   assign send       = |(pressed_ff ^ confirmed_ff);

   always_comb begin
      for (int i = 0; i < N; i++) begin
         hit[i]          = req_payload.button_index == 2'(i);
         lock_clear[i]   = (req_payload.now_ms - last_press_ff[i]) > {16'd0, lockout_ff};
         hold_expired[i] = (req_payload.now_ms - last_press_ff[i]) > {16'd0, hold_ff};
         write_en[i]     = 2'(i) < req_payload.state_count;
      end
   end

   always_comb begin
      pressed_in     = pressed_ff;
      released_in    = released_ff;
      confirmed_in   = confirmed_ff;
      led_in         = led_ff;
      last_press_in  = last_press_ff;
      last_report_in = last_report_ff;
      pressed_mask   = '0;
      rsp_in         = '0;
      for (int i = 0; i < N && i < bpr_pkg::MASK_W; i++) begin
         pressed_mask[i] = pressed_ff[i];
      end
      unique case (bpr_pkg::kind_type'(req_payload.kind))
         bpr_pkg::KIND_PIN: begin
            for (int i = 0; i < N; i++) begin
               if (hit[i]) begin
                  if (req_payload.level) begin
                     released_in[i] = 1'b1;
                  end else if (lock_clear[i]) begin
                     pressed_in[i]    = 1'b1;
                     released_in[i]   = 1'b0;
                     last_press_in[i] = req_payload.now_ms;
                  end
               end
            end
         end
         bpr_pkg::KIND_TICK: begin
            if (tick_due) begin
               last_report_in      = req_payload.now_ms;
               rsp_in.report_valid = send;
               rsp_in.report_mask  = send ? pressed_mask : '0;
               for (int i = 0; i < N; i++) begin
                  if ((!send && released_ff[i]) || hold_expired[i]) begin
                     pressed_in[i]   = 1'b0;
                     confirmed_in[i] = 1'b0;
                  end
               end
            end
         end
         bpr_pkg::KIND_CONFIRM: begin
            for (int i = 0; i < N && i < bpr_pkg::MASK_W; i++) begin
               if (write_en[i]) confirmed_in[i] = req_payload.state_mask[i];
            end
         end
         bpr_pkg::KIND_LED: begin
            for (int i = 0; i < N && i < bpr_pkg::MASK_W; i++) begin
               if (write_en[i]) led_in[i] = req_payload.state_mask[i];
            end
         end
         default: ;
      endcase
      led_mask_next = '0;
      for (int i = 0; i < N && i < bpr_pkg::MASK_W; i++) begin
         led_mask_next[i] = led_in[i];
      end
      rsp_in.led_mask = led_mask_next;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (req_fire)  rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff     <= bpr_pkg::LOCKOUT_RESET;
         period_ff      <= bpr_pkg::PERIOD_RESET;
         hold_ff        <= bpr_pkg::HOLD_RESET;
         pressed_ff     <= '0;
         released_ff    <= '1;
         confirmed_ff   <= '0;
         led_ff         <= '0;
         last_report_ff <= '0;
         for (int i = 0; i < N; i++) last_press_ff[i] <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         lockout_ff   <= lockout_in;
         period_ff    <= period_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            pressed_ff     <= pressed_in;
            released_ff    <= released_in;
            confirmed_ff   <= confirmed_in;
            led_ff         <= led_in;
            last_press_ff  <= last_press_in;
            last_report_ff <= last_report_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) rsp_ff <= rsp_in;
   end

endmodule

// File: rtl/bpr_checker.sv
// ----------------------------------------------------------------------------
// bpr_checker
// Port-level checks on the button press reporter, bound to the top level.
// ----------------------------------------------------------------------------
module bpr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input bpr_pkg::rsp_type              rsp_payload
);

   // every request transfer yields a response in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after request transfer");

   a_quiet_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.report_valid |-> rsp_payload.report_mask == '0)
      else $error("report mask set without report");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

endmodule

bind button_press_report_with_ack bpr_checker u_bpr_checker (.*);
